### rtl/core/pbwm_pkg.sv
`default_nettype none

package pbwm_pkg;

    // field and register widths
    localparam int WORD_BITS     = 16;
    localparam int BYTE_BITS     = 8;
    localparam int ADDR_BITS_DEF = 16;
    localparam int CFG_COUNT     = 8;
    localparam int CFG_IDX_BITS  = 3;
    localparam int RANGE_COUNT   = 4;

    localparam logic [WORD_BITS-1:0] LOW_BYTE_MASK = 16'h00FF;

    // access codes on s_mode
    typedef enum logic [1:0] {
        MODE_RD_BYTE = 2'd0,
        MODE_RD_WORD = 2'd1,
        MODE_WR_BYTE = 2'd2,
        MODE_WR_WORD = 2'd3
    } mode_t;

    // result status codes
    typedef enum logic [1:0] {
        STAT_OK   = 2'd0,
        STAT_PRIV = 2'd1,
        STAT_LAST = 2'd2
    } status_t;

    // protected-range lookup for the two bytes of an access
    typedef struct packed {
        logic lo;
        logic hi;
    } prot_hit_t;

    typedef logic [WORD_BITS-1:0] cfg_word_t;

    // reset values of the range registers: rom, audio, input, syscall (start, end)
    localparam cfg_word_t CFG_RESET [CFG_COUNT] = '{
        16'd0, 16'd32767,
        16'd1, 16'd0,
        16'd1, 16'd0,
        16'd1, 16'd0
    };

endpackage

`default_nettype wire

### rtl/core/pbwm_ram.sv
`default_nettype none

module pbwm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     en,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // single port, registered read; read data holds while the port is idle
    always_ff @(posedge clk) begin
        if (en) begin
            if (we) begin
                mem[addr] <= wdata;
            end else begin
                rdata_reg <= mem[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

### rtl/core/pbwm_prot.sv
`default_nettype none

module pbwm_prot (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             cfg_wr_en,
    input  wire logic [pbwm_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  wire logic [pbwm_pkg::WORD_BITS-1:0]    cfg_data,
    input  wire logic [pbwm_pkg::WORD_BITS-1:0]    addr_lo,
    input  wire logic [pbwm_pkg::WORD_BITS-1:0]    addr_hi,
    output pbwm_pkg::prot_hit_t                    hit
);

    import pbwm_pkg::*;

    cfg_word_t cfg_reg  [CFG_COUNT];
    cfg_word_t cfg_next [CFG_COUNT];

    // range register file
    always_comb begin
        for (int i = 0; i < CFG_COUNT; i++) begin
            cfg_next[i] = cfg_reg[i];
        end
        if (cfg_wr_en) begin
            cfg_next[cfg_index] = cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < CFG_COUNT; i++) begin
                cfg_reg[i] <= CFG_RESET[i];
            end
        end else begin
            for (int i = 0; i < CFG_COUNT; i++) begin
                cfg_reg[i] <= cfg_next[i];
            end
        end
    end

    // inclusive range compare for both byte addresses; start above end never hits
    always_comb begin
        hit.lo = 1'b0;
        hit.hi = 1'b0;
        for (int r = 0; r < RANGE_COUNT; r++) begin
            if (addr_lo >= cfg_reg[2*r] && addr_lo <= cfg_reg[2*r+1]) begin
                hit.lo = 1'b1;
            end
            if (addr_hi >= cfg_reg[2*r] && addr_hi <= cfg_reg[2*r+1]) begin
                hit.hi = 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

### rtl/core/protected_byte_word_memory.sv
`default_nettype none

// channel   | direction | ports
// ----------+-----------+--------------------------------------------------------
// access    | in        | s_valid, s_ready, s_mode, s_address, s_write_data,
//           |           | s_privileged
// result    | out       | m_valid, m_ready, m_read_data, m_status
// range cfg | in        | cfg_wr_en, cfg_index, cfg_data
//
// One access word per cycle while s_ready is high; an accepted access passes the bank read
// and read stage, then the result register, which drives m_valid.
// The store is two byte banks (even and odd addresses), one port each, so any word,
// aligned or not, touches each bank once.
// After reset the banks are cleared one row per cycle, all 2^(ADDR_BITS-1) rows
// (32768 at the default), during which s_ready is low; range writes are taken throughout.
// A stalled result holds the one access behind it in the read stage; then s_ready drops.

module protected_byte_word_memory #(
    parameter int ADDR_BITS = pbwm_pkg::ADDR_BITS_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic [1:0]                        s_mode,
    input  wire logic [pbwm_pkg::WORD_BITS-1:0]     s_address,
    input  wire logic [pbwm_pkg::WORD_BITS-1:0]     s_write_data,
    input  wire logic                              s_privileged,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic      [pbwm_pkg::WORD_BITS-1:0]     m_read_data,
    output logic      [1:0]                        m_status,
    input  wire logic                              cfg_wr_en,
    input  wire logic [pbwm_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  wire logic [pbwm_pkg::WORD_BITS-1:0]     cfg_data
);

    import pbwm_pkg::*;

    localparam int ROW_BITS = ADDR_BITS - 1;
    localparam int ROWS     = 1 << ROW_BITS;

    // clear sweep
    logic                clr_busy_reg, clr_busy_next;
    logic [ROW_BITS-1:0] clr_row_reg, clr_row_next;

    // read stage
    logic    pend_valid_reg, pend_valid_next;
    logic    pend_word_reg, pend_word_next;
    logic    pend_odd_reg, pend_odd_next;
    logic    pend_rd_reg, pend_rd_next;
    status_t pend_status_reg, pend_status_next;

    // result register
    logic                 m_valid_reg, m_valid_next;
    logic [WORD_BITS-1:0] m_read_data_reg, m_read_data_next;
    status_t              m_status_reg, m_status_next;

    logic [ADDR_BITS-1:0] addr_a, addr_b;
    logic [WORD_BITS-1:0] addr_a_ext, addr_b_ext;
    logic [ROW_BITS-1:0]  row, row_inc;
    logic [WORD_BITS-1:0] wdata_lo;
    mode_t                mode;
    prot_hit_t            hit;
    logic                 accept, out_free, is_write, is_word, last, priv_fail;
    logic                 do_write, do_read;
    status_t              status;

    logic                 ev_en, ev_we, od_en, od_we;
    logic [ROW_BITS-1:0]  ev_addr, od_addr;
    logic [BYTE_BITS-1:0] ev_wdata, od_wdata, ev_rdata, od_rdata;
    logic [BYTE_BITS-1:0] rd_lo, rd_hi;

    // address of both bytes, masked to the store size
    always_comb begin
        addr_a     = s_address[ADDR_BITS-1:0];
        addr_b     = addr_a + {{(ADDR_BITS-1){1'b0}}, 1'b1};
        addr_a_ext = '0;
        addr_b_ext = '0;
        addr_a_ext[ADDR_BITS-1:0] = addr_a;
        addr_b_ext[ADDR_BITS-1:0] = addr_b;
        row        = addr_a[ADDR_BITS-1:1];
        row_inc    = row + {{(ROW_BITS-1){1'b0}}, 1'b1};
        last       = &addr_a;
    end

    pbwm_prot u_prot (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .addr_lo   (addr_a_ext),
        .addr_hi   (addr_b_ext),
        .hit       (hit)
    );

    // handshake
    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = !clr_busy_reg && (!pend_valid_reg || out_free);
    assign accept   = s_valid && s_ready;

    // decode and status
    always_comb begin
        mode      = mode_t'(s_mode);
        is_write  = (mode == MODE_WR_BYTE) || (mode == MODE_WR_WORD);
        is_word   = (mode == MODE_RD_WORD) || (mode == MODE_WR_WORD);
        priv_fail = !s_privileged && (hit.lo || (is_word && hit.hi));
        case (mode)
            MODE_RD_BYTE: status = STAT_OK;
            MODE_RD_WORD: status = last ? STAT_LAST : STAT_OK;
            MODE_WR_BYTE: status = priv_fail ? STAT_PRIV : STAT_OK;
            MODE_WR_WORD: status = priv_fail ? STAT_PRIV : (last ? STAT_LAST : STAT_OK);
            default:      status = STAT_OK;
        endcase
        do_write = accept && is_write && (status == STAT_OK);
        do_read  = accept && !is_write && (status == STAT_OK);
    end

    // bank steering; an odd word puts its high byte in the next even row
    always_comb begin
        wdata_lo = s_write_data & LOW_BYTE_MASK;
        if (clr_busy_reg) begin
            ev_en    = 1'b1;
            ev_we    = 1'b1;
            ev_addr  = clr_row_reg;
            ev_wdata = '0;
            od_en    = 1'b1;
            od_we    = 1'b1;
            od_addr  = clr_row_reg;
            od_wdata = '0;
        end else begin
            ev_en    = do_read || (do_write && (is_word || !addr_a[0]));
            ev_we    = do_write && (is_word || !addr_a[0]);
            ev_addr  = (is_word && addr_a[0]) ? row_inc : row;
            ev_wdata = addr_a[0] ? s_write_data[WORD_BITS-1:BYTE_BITS]
                                 : wdata_lo[BYTE_BITS-1:0];
            od_en    = do_read || (do_write && (is_word || addr_a[0]));
            od_we    = do_write && (is_word || addr_a[0]);
            od_addr  = row;
            od_wdata = addr_a[0] ? wdata_lo[BYTE_BITS-1:0]
                                 : s_write_data[WORD_BITS-1:BYTE_BITS];
        end
    end

    pbwm_ram #(
        .WIDTH (BYTE_BITS),
        .DEPTH (ROWS)
    ) u_even_bank (
        .clk   (aclk),
        .en    (ev_en),
        .we    (ev_we),
        .addr  (ev_addr),
        .wdata (ev_wdata),
        .rdata (ev_rdata)
    );

    pbwm_ram #(
        .WIDTH (BYTE_BITS),
        .DEPTH (ROWS)
    ) u_odd_bank (
        .clk   (aclk),
        .en    (od_en),
        .we    (od_we),
        .addr  (od_addr),
        .wdata (od_wdata),
        .rdata (od_rdata)
    );

    // next state: clear sweep, read stage, result register
    always_comb begin
        clr_busy_next = clr_busy_reg;
        clr_row_next  = clr_row_reg;
        if (clr_busy_reg) begin
            clr_row_next = clr_row_reg + {{(ROW_BITS-1){1'b0}}, 1'b1};
            if (&clr_row_reg) begin
                clr_busy_next = 1'b0;
            end
        end

        pend_valid_next  = pend_valid_reg;
        pend_word_next   = pend_word_reg;
        pend_odd_next    = pend_odd_reg;
        pend_rd_next     = pend_rd_reg;
        pend_status_next = pend_status_reg;
        if (accept) begin
            pend_valid_next  = 1'b1;
            pend_word_next   = is_word;
            pend_odd_next    = addr_a[0];
            pend_rd_next     = do_read;
            pend_status_next = status;
        end else if (out_free) begin
            pend_valid_next  = 1'b0;
        end

        // byte lanes back into address order
        rd_lo = pend_odd_reg ? od_rdata : ev_rdata;
        rd_hi = pend_odd_reg ? ev_rdata : od_rdata;

        m_valid_next     = m_valid_reg;
        m_read_data_next = m_read_data_reg;
        m_status_next    = m_status_reg;
        if (out_free) begin
            m_valid_next = pend_valid_reg;
            if (pend_valid_reg) begin
                m_status_next = pend_status_reg;
                if (!pend_rd_reg) begin
                    m_read_data_next = '0;
                end else if (pend_word_reg) begin
                    m_read_data_next = {rd_hi, rd_lo};
                end else begin
                    m_read_data_next = {{(WORD_BITS-BYTE_BITS){1'b0}}, rd_lo};
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_busy_reg   <= 1'b1;
            clr_row_reg    <= '0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            clr_busy_reg   <= clr_busy_next;
            clr_row_reg    <= clr_row_next;
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pend_word_reg   <= pend_word_next;
        pend_odd_reg    <= pend_odd_next;
        pend_rd_reg     <= pend_rd_next;
        pend_status_reg <= pend_status_next;
        m_read_data_reg <= m_read_data_next;
        m_status_reg    <= m_status_next;
    end

    assign m_valid     = m_valid_reg;
    assign m_read_data = m_read_data_reg;
    assign m_status    = m_status_reg;

    // checks
    a_err_zero_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && (m_status_reg != STAT_OK) |-> m_read_data_reg == '0)
        else $error("error result carries nonzero read data");

    a_clear_full: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(clr_busy_reg) |-> &$past(clr_row_reg))
        else $error("clear sweep ended before the last row");

    a_clear_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        clr_busy_reg |-> !pend_valid_reg && !m_valid_reg)
        else $error("access in flight during clear sweep");

    a_pend_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(pend_valid_reg) |-> $past(s_valid && s_ready))
        else $error("read stage filled without an accepted access");

endmodule

`default_nettype wire

### tb/tb.sv
import pbwm_pkg::*;

// range register indexes on cfg_index
typedef enum int {
    REG_ROM_START,
    REG_ROM_END,
    REG_AUDIO_START,
    REG_AUDIO_END,
    REG_INPUT_START,
    REG_INPUT_END,
    REG_SYSCALL_START,
    REG_SYSCALL_END
} range_reg_e;

localparam logic [WORD_BITS-1:0] LAST_ADDR = 16'hFFFF;

typedef struct {
    logic [WORD_BITS-1:0] read_data;
    status_t              status;
} mem_result_t;

// Shadow copy of the byte store and the guarded ranges; predicts each result word
class store_shadow;
    logic [BYTE_BITS-1:0] image [0:65535];
    cfg_word_t            spans [CFG_COUNT];
    mem_result_t          expected_results [$];
    int                   mismatches;

    function new();
        foreach (image[i]) image[i] = '0;
        foreach (spans[i]) spans[i] = CFG_RESET[i];
        mismatches = 0;
    endfunction

    function void set_span(int idx, cfg_word_t value);
        spans[idx] = value;
    endfunction

    function bit guarded(logic [WORD_BITS-1:0] addr);
        for (int r = 0; r < RANGE_COUNT; r++) begin
            if (addr >= spans[REG_ROM_START + 2*r] && addr <= spans[REG_ROM_END + 2*r])
                return 1'b1;
        end
        return 1'b0;
    endfunction

    function int pending();
        return expected_results.size();
    endfunction

    // apply one accepted access word and queue its result
    function void take_access(mode_t mode, logic [WORD_BITS-1:0] addr,
                              logic [WORD_BITS-1:0] data, logic priv);
        logic [WORD_BITS-1:0] nxt;
        mem_result_t          res;
        nxt = addr + 16'd1;
        res.read_data = '0;
        res.status = STAT_OK;
        case (mode)
            MODE_RD_BYTE: begin
                res.read_data = {8'h00, image[addr]};
            end
            MODE_RD_WORD: begin
                if (addr == LAST_ADDR) res.status = STAT_LAST;
                else res.read_data = {image[nxt], image[addr]};
            end
            MODE_WR_BYTE: begin
                if (!priv && guarded(addr)) res.status = STAT_PRIV;
                else image[addr] = data[7:0];
            end
            default: begin
                // privilege check first; the upper byte address wraps to 0
                if (!priv && (guarded(addr) || guarded(nxt))) begin
                    res.status = STAT_PRIV;
                end else if (addr == LAST_ADDR) begin
                    res.status = STAT_LAST;
                end else begin
                    image[addr] = data[7:0];
                    image[nxt] = data[15:8];
                end
            end
        endcase
        expected_results.push_back(res);
    endfunction

    function void match_result(logic [WORD_BITS-1:0] rd, logic [1:0] st);
        mem_result_t want;
        if (expected_results.size() == 0) begin
            mismatches++;
            $display("%0t: result word with none pending: read_data %h status %0d",
                     $time, rd, st);
            return;
        end
        want = expected_results.pop_front();
        if (rd !== want.read_data) begin
            mismatches++;
            $display("%0t: read_data expected %h, got %h", $time, want.read_data, rd);
        end
        if (st !== want.status) begin
            mismatches++;
            $display("%0t: status expected %0d, got %0d", $time, want.status, st);
        end
    endfunction
endclass

module tb;
    localparam int unsigned CYCLE_LIMIT    = 400000;
    localparam int          PHASES         = 6;
    localparam int          RAND_PER_PHASE = 134;
    localparam int          LONG_HOLD      = 80;

    logic                    aclk;
    logic                    aresetn;
    logic                    s_valid;
    logic                    s_ready;
    logic [1:0]              s_mode;
    logic [WORD_BITS-1:0]    s_address;
    logic [WORD_BITS-1:0]    s_write_data;
    logic                    s_privileged;
    logic                    m_valid;
    logic                    m_ready;
    logic [WORD_BITS-1:0]    m_read_data;
    logic [1:0]              m_status;
    logic                    cfg_wr_en;
    logic [CFG_IDX_BITS-1:0] cfg_index;
    logic [WORD_BITS-1:0]    cfg_data;

    store_shadow shadow;
    cfg_word_t   plan [CFG_COUNT];
    bit          tx_fast = 1'b0;
    bit          rx_fast = 1'b0;
    bit          rx_hold_req = 1'b0;
    int unsigned cycle_count = 0;

    protected_byte_word_memory u_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_mode       (s_mode),
        .s_address    (s_address),
        .s_write_data (s_write_data),
        .s_privileged (s_privileged),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_read_data  (m_read_data),
        .m_status     (m_status),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // watchdog, sized well past the clearing pass plus the slowest run
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            shadow.match_result(m_read_data, m_status);
    end

    // result side: random stalls, bursts with none, one long hold on request
    initial begin : result_sink
        int stall;
        m_ready = 1'b0;
        @(posedge aresetn);
        @(negedge aclk);
        forever begin
            stall = rx_fast ? 0 : $urandom_range(0, 4);
            if ($urandom_range(0, 39) == 0) rx_fast = !rx_fast;
            if (rx_hold_req) begin
                stall = LONG_HOLD;
                rx_hold_req = 1'b0;
            end
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            @(negedge aclk);
        end
    end

    // offer one access word; entered and left at a falling edge
    task automatic send_access(mode_t mode, logic [WORD_BITS-1:0] addr,
                               logic [WORD_BITS-1:0] data, logic priv);
        int gap;
        gap = tx_fast ? 0 : $urandom_range(0, 4);
        if ($urandom_range(0, 39) == 0) tx_fast = !tx_fast;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_mode <= mode;
        s_address <= addr;
        s_write_data <= data;
        s_privileged <= priv;
        do @(posedge aclk); while (!s_ready);
        shadow.take_access(mode, addr, data, priv);
        @(negedge aclk);
    endtask

    // drop valid and wait out every outstanding result
    task automatic settle();
        s_valid <= 1'b0;
        while (shadow.pending() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic load_plan();
        for (int i = 0; i < CFG_COUNT; i++) begin
            cfg_wr_en <= 1'b1;
            cfg_index <= CFG_IDX_BITS'(i);
            cfg_data <= plan[i];
            shadow.set_span(i, plan[i]);
            @(negedge aclk);
        end
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
    endtask

    // ranges near the working window, about a quarter of them empty
    function automatic void plan_random_spans(logic [WORD_BITS-1:0] win);
        logic [WORD_BITS-1:0] lo;
        for (int r = 0; r < RANGE_COUNT; r++) begin
            if ($urandom_range(0, 3) == 0) begin
                lo = 16'($urandom_range(1, 65535));
                plan[REG_ROM_START + 2*r] = lo;
                plan[REG_ROM_END + 2*r] = 16'($urandom_range(0, lo - 1));
            end else begin
                lo = win + 16'($urandom_range(0, 200));
                plan[REG_ROM_START + 2*r] = lo;
                plan[REG_ROM_END + 2*r] = lo + 16'($urandom_range(0, 40));
            end
        end
    endfunction

    // half the time a small window so reads land on earlier writes; else range edges,
    // the wrap corner and fully random addresses
    task automatic random_access(logic [WORD_BITS-1:0] win);
        logic [WORD_BITS-1:0] addr;
        int                   pick;
        pick = $urandom_range(0, 9);
        if (pick < 5)
            addr = win + 16'($urandom_range(0, 255));
        else if (pick < 7)
            addr = shadow.spans[$urandom_range(0, CFG_COUNT - 1)]
                   + 16'($urandom_range(0, 2)) - 16'd1;
        else if (pick == 7)
            addr = LAST_ADDR - 16'd1 + 16'($urandom_range(0, 3));
        else
            addr = 16'($urandom);
        send_access(mode_t'($urandom_range(0, 3)), addr, 16'($urandom),
                    $urandom_range(0, 2) == 0);
    endtask

    initial begin : stimulus
        logic [WORD_BITS-1:0] win;
        s_valid = 1'b0;
        s_mode = MODE_RD_BYTE;
        s_address = '0;
        s_write_data = '0;
        s_privileged = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        aresetn = 1'b0;
        shadow = new();
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // reset ranges: rom guards the low half, the rest are empty
        send_access(MODE_WR_BYTE, 16'h0000, 16'hFFFF, 1'b0);
        send_access(MODE_WR_BYTE, 16'h0000, 16'hFFA5, 1'b1);
        send_access(MODE_RD_BYTE, 16'h0000, 16'h0000, 1'b0);
        send_access(MODE_WR_WORD, 16'h8000, 16'h1234, 1'b0);
        send_access(MODE_RD_WORD, 16'h8000, 16'hFFFF, 1'b1);
        send_access(MODE_RD_BYTE, 16'h8001, 16'h0000, 1'b0);
        // unaligned word across the rom edge
        send_access(MODE_WR_WORD, 16'h7FFF, 16'hBEEF, 1'b0);
        send_access(MODE_WR_WORD, 16'h7FFF, 16'hBEEF, 1'b1);
        send_access(MODE_RD_WORD, 16'h7FFF, 16'h0000, 1'b0);
        // last address: upper byte wraps into rom, then the last-address refusal
        send_access(MODE_WR_WORD, LAST_ADDR, 16'h5555, 1'b0);
        send_access(MODE_WR_WORD, LAST_ADDR, 16'h5555, 1'b1);
        send_access(MODE_RD_WORD, LAST_ADDR, 16'h0000, 1'b0);
        send_access(MODE_WR_BYTE, LAST_ADDR, 16'hFF77, 1'b0);
        send_access(MODE_RD_BYTE, LAST_ADDR, 16'h0000, 1'b0);
        send_access(MODE_RD_WORD, 16'hFFFE, 16'h0000, 1'b0);
        send_access(MODE_WR_WORD, 16'hFFFE, 16'hFFFF, 1'b0);
        send_access(MODE_RD_WORD, 16'hFFFE, 16'h0000, 1'b0);
        send_access(MODE_RD_BYTE, 16'h0001, 16'h0000, 1'b0);
        send_access(MODE_WR_WORD, 16'hAAAA, 16'h0000, 1'b1);
        send_access(MODE_RD_WORD, 16'h5555, 16'h0000, 1'b1);
        settle();

        // every range empty: an unprivileged word write at the last address
        // passes the guard and is refused for the address alone
        foreach (plan[i]) plan[i] = (i % 2 == 0) ? 16'hFFFF : 16'h0000;
        load_plan();
        send_access(MODE_WR_WORD, LAST_ADDR, 16'hA5A5, 1'b0);
        send_access(MODE_WR_WORD, 16'h0000, 16'h0102, 1'b0);
        send_access(MODE_RD_WORD, 16'h0000, 16'h0000, 1'b0);
        settle();

        for (int ph = 0; ph < PHASES; ph++) begin
            win = 16'($urandom);
            if (ph == 1) begin
                // single-address and edge-of-space ranges
                plan[REG_ROM_START] = 16'h1000;
                plan[REG_ROM_END] = 16'h10FF;
                plan[REG_AUDIO_START] = 16'h2000;
                plan[REG_AUDIO_END] = 16'h2000;
                plan[REG_INPUT_START] = LAST_ADDR;
                plan[REG_INPUT_END] = LAST_ADDR;
                plan[REG_SYSCALL_START] = 16'h0000;
                plan[REG_SYSCALL_END] = 16'h0000;
                win = 16'h0F80;
            end else if (ph >= 2) begin
                plan_random_spans(win);
                if (ph == 2) begin
                    // rom guards the whole space
                    plan[REG_ROM_START] = 16'h0000;
                    plan[REG_ROM_END] = LAST_ADDR;
                end
            end
            load_plan();
            for (int n = 0; n < RAND_PER_PHASE; n++) begin
                if (ph == 3 && n == 50) rx_hold_req = 1'b1;
                random_access(win);
            end
            settle();
        end

        if (shadow.mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
